// ===== hdl/rgbhsl_pkg.sv =====
`timescale 1ns / 1ps

package rgbhsl_pkg;

  // Fixed result widths
  localparam int HUE_BITS   = 15;
  localparam int SAT_BITS   = 16;
  localparam int ALPHA_BITS = 8;

  // Hue units per sixth of the color wheel (60 degrees at 1/64 degree)
  localparam int HUE_SEXTANT = 3840;

  // Quotient bits developed by the divider row; one cell per bit
  localparam int QUO_BITS = 17;

  // Fractional bits of the saturation ratio
  localparam int SAT_FRAC = 16;

  // Sextant bits (0..5)
  localparam int SEXT_BITS = 3;

  // Pixel control that travels alongside the division
  typedef struct packed {
    logic                  valid;
    logic                  grey;
    logic [SEXT_BITS-1:0]  sext;
    logic [ALPHA_BITS-1:0] alpha;
  } pix_ctrl_t;

endpackage

// ===== hdl/rgbhsl_front.sv =====
`timescale 1ns / 1ps

module rgbhsl_front
  import rgbhsl_pkg::*;
#(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [CHANNEL_BITS-1:0] red_in,
  input  logic [CHANNEL_BITS-1:0] green_in,
  input  logic [CHANNEL_BITS-1:0] blue_in,
  input  logic [ALPHA_BITS-1:0]   alpha_in,
  output pix_ctrl_t               ctrl,
  output logic [CHANNEL_BITS:0]   sum,
  output logic [CHANNEL_BITS-1:0] hue_rem,
  output logic [QUO_BITS-1:0]     hue_acc,
  output logic [CHANNEL_BITS-1:0] hue_div,
  output logic [CHANNEL_BITS-1:0] sat_rem,
  output logic [QUO_BITS-1:0]     sat_acc,
  output logic [CHANNEL_BITS-1:0] sat_div
);

  localparam int CB = CHANNEL_BITS;
  localparam int DW = CB + QUO_BITS;
  localparam logic [CB:0] FULL = (CB+1)'((1 << CB) - 1);

  logic              red_max;
  logic              green_max;
  logic [CB-1:0]     hi;
  logic [CB-1:0]     lo;
  logic [CB-1:0]     d;
  logic [CB:0]       s;
  logic [CB:0]       x_wide;
  logic [CB-1:0]     x;
  logic [SEXT_BITS-1:0] k;
  logic [CB-1:0]     den;
  logic [DW-1:0]     hue_dvd;
  logic [DW-1:0]     sat_dvd;

  // Pick the largest channel (red wins ties, then green) and the smallest
  always_comb begin
    red_max   = (red_in >= green_in) && (red_in >= blue_in);
    green_max = !red_max && (green_in >= blue_in);
    priority if (red_max) begin
      hi = red_in;
    end else if (green_max) begin
      hi = green_in;
    end else begin
      hi = blue_in;
    end
    lo = red_in;
    if (green_in < lo) begin
      lo = green_in;
    end
    if (blue_in < lo) begin
      lo = blue_in;
    end
    d = hi - lo;
    s = {1'b0, hi} + {1'b0, lo};
  end

  // Fold the signed hue difference into a sextant and a nonnegative fraction
  always_comb begin
    priority if (red_max) begin
      if (green_in >= blue_in) begin
        k      = SEXT_BITS'(0);
        x_wide = {1'b0, green_in} - {1'b0, blue_in};
      end else begin
        k      = SEXT_BITS'(5);
        x_wide = {1'b0, d} + {1'b0, green_in} - {1'b0, blue_in};
      end
    end else if (green_max) begin
      if (blue_in >= red_in) begin
        k      = SEXT_BITS'(2);
        x_wide = {1'b0, blue_in} - {1'b0, red_in};
      end else begin
        k      = SEXT_BITS'(1);
        x_wide = {1'b0, d} + {1'b0, blue_in} - {1'b0, red_in};
      end
    end else begin
      if (red_in >= green_in) begin
        k      = SEXT_BITS'(4);
        x_wide = {1'b0, red_in} - {1'b0, green_in};
      end else begin
        k      = SEXT_BITS'(3);
        x_wide = {1'b0, d} + {1'b0, red_in} - {1'b0, green_in};
      end
    end
    x = x_wide[CB-1:0];
  end

  // Form the saturation divisor and both dividends
  always_comb begin
    if (s >= FULL) begin
      den = CB'((FULL << 1) - s);
    end else begin
      den = s[CB-1:0];
    end
    hue_dvd = DW'(x) * DW'(HUE_SEXTANT);
    sat_dvd = DW'(d) << SAT_FRAC;
  end

  // Register the prepared transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.valid <= 1'b0;
    end else begin
      ctrl.valid <= start;
    end
    ctrl.grey  <= (d == '0);
    ctrl.sext  <= k;
    ctrl.alpha <= alpha_in;
    sum        <= s;
    hue_rem    <= hue_dvd[DW-1:QUO_BITS];
    hue_acc    <= hue_dvd[QUO_BITS-1:0];
    hue_div    <= d;
    sat_rem    <= sat_dvd[DW-1:QUO_BITS];
    sat_acc    <= sat_dvd[QUO_BITS-1:0];
    sat_div    <= den;
  end

endmodule

// ===== hdl/rgbhsl_cell.sv =====
`timescale 1ns / 1ps

module rgbhsl_cell
  import rgbhsl_pkg::*;
#(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  pix_ctrl_t               ctrl_in,
  input  logic [CHANNEL_BITS:0]   sum_in,
  input  logic [CHANNEL_BITS-1:0] hue_rem_in,
  input  logic [QUO_BITS-1:0]     hue_acc_in,
  input  logic [CHANNEL_BITS-1:0] hue_div_in,
  input  logic [CHANNEL_BITS-1:0] sat_rem_in,
  input  logic [QUO_BITS-1:0]     sat_acc_in,
  input  logic [CHANNEL_BITS-1:0] sat_div_in,
  output pix_ctrl_t               ctrl_out,
  output logic [CHANNEL_BITS:0]   sum_out,
  output logic [CHANNEL_BITS-1:0] hue_rem_out,
  output logic [QUO_BITS-1:0]     hue_acc_out,
  output logic [CHANNEL_BITS-1:0] hue_div_out,
  output logic [CHANNEL_BITS-1:0] sat_rem_out,
  output logic [QUO_BITS-1:0]     sat_acc_out,
  output logic [CHANNEL_BITS-1:0] sat_div_out
);

  localparam int CB = CHANNEL_BITS;

  logic [CB:0]   hue_t;
  logic [CB:0]   hue_diff;
  logic          hue_bit;
  logic [CB-1:0] hue_rem_next;
  logic [CB:0]   sat_t;
  logic [CB:0]   sat_diff;
  logic          sat_bit;
  logic [CB-1:0] sat_rem_next;

  // One restoring division step for hue: shift in a dividend bit, try subtract
  always_comb begin
    hue_t        = {hue_rem_in, hue_acc_in[QUO_BITS-1]};
    hue_diff     = hue_t - {1'b0, hue_div_in};
    hue_bit      = (hue_t >= {1'b0, hue_div_in});
    hue_rem_next = hue_bit ? hue_diff[CB-1:0] : hue_t[CB-1:0];
  end

  // Same step for saturation
  always_comb begin
    sat_t        = {sat_rem_in, sat_acc_in[QUO_BITS-1]};
    sat_diff     = sat_t - {1'b0, sat_div_in};
    sat_bit      = (sat_t >= {1'b0, sat_div_in});
    sat_rem_next = sat_bit ? sat_diff[CB-1:0] : sat_t[CB-1:0];
  end

  // Advance the transaction to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out.valid <= 1'b0;
    end else begin
      ctrl_out.valid <= ctrl_in.valid;
    end
    ctrl_out.grey  <= ctrl_in.grey;
    ctrl_out.sext  <= ctrl_in.sext;
    ctrl_out.alpha <= ctrl_in.alpha;
    sum_out        <= sum_in;
    hue_rem_out    <= hue_rem_next;
    hue_acc_out    <= {hue_acc_in[QUO_BITS-2:0], hue_bit};
    hue_div_out    <= hue_div_in;
    sat_rem_out    <= sat_rem_next;
    sat_acc_out    <= {sat_acc_in[QUO_BITS-2:0], sat_bit};
    sat_div_out    <= sat_div_in;
  end

endmodule

// ===== hdl/rgb_to_hsl_converter.sv =====
`timescale 1ns / 1ps
// RGB to HSL converter.
// Input: pulse start with a pixel on red_in, green_in, blue_in, alpha_in.
// A transaction is taken at every clock edge where start is high and busy
// is low; busy is always low, so a new pixel may enter every cycle.
// Output: done is high for exactly one cycle with hue (1/64 degree),
// saturation (Q0.16, full given as 65535), lightness_sum (max plus min
// channel), alpha_out and is_grey. The receiver cannot stall; results must
// be taken in the cycle they appear.
// Path: channel sorting in the front register, 17 cells of the division
// row, then the final assembly register that drives done.
// Throughput: one pixel per clock; each cell of the row develops one
// quotient bit of both the hue and the saturation division.
// Reset (rst, synchronous) drops every transaction in flight; no result
// appears for pixels accepted before reset.
// Grey pixels give hue 0 and saturation 0 with is_grey set.

module rgb_to_hsl_converter
  import rgbhsl_pkg::*;
#(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [CHANNEL_BITS-1:0] red_in,
  input  logic [CHANNEL_BITS-1:0] green_in,
  input  logic [CHANNEL_BITS-1:0] blue_in,
  input  logic [ALPHA_BITS-1:0]   alpha_in,
  output logic                    done,
  output logic [HUE_BITS-1:0]     hue,
  output logic [SAT_BITS-1:0]     saturation,
  output logic [CHANNEL_BITS:0]   lightness_sum,
  output logic [ALPHA_BITS-1:0]   alpha_out,
  output logic                    is_grey
);

  localparam int CB      = CHANNEL_BITS;
  localparam int LATENCY = QUO_BITS + 2;

  pix_ctrl_t     ctrl    [0:QUO_BITS];
  logic [CB:0]   sum     [0:QUO_BITS];
  logic [CB-1:0] hue_rem [0:QUO_BITS];
  logic [QUO_BITS-1:0] hue_acc [0:QUO_BITS];
  logic [CB-1:0] hue_div [0:QUO_BITS];
  logic [CB-1:0] sat_rem [0:QUO_BITS];
  logic [QUO_BITS-1:0] sat_acc [0:QUO_BITS];
  logic [CB-1:0] sat_div [0:QUO_BITS];

  pix_ctrl_t           last;
  logic [QUO_BITS-1:0] hue_q;
  logic [QUO_BITS-1:0] sat_q;
  logic [HUE_BITS-1:0] hue_next;
  logic [SAT_BITS-1:0] saturation_next;

  // Accept a pixel every cycle
  assign busy = 1'b0;

  // Sort channels and prepare both divisions
  rgbhsl_front #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .red_in   (red_in),
    .green_in (green_in),
    .blue_in  (blue_in),
    .alpha_in (alpha_in),
    .ctrl     (ctrl[0]),
    .sum      (sum[0]),
    .hue_rem  (hue_rem[0]),
    .hue_acc  (hue_acc[0]),
    .hue_div  (hue_div[0]),
    .sat_rem  (sat_rem[0]),
    .sat_acc  (sat_acc[0]),
    .sat_div  (sat_div[0])
  );

  // Row of division cells, one quotient bit each
  for (genvar i = 0; i < QUO_BITS; i++) begin : g_cell
    rgbhsl_cell #(
      .CHANNEL_BITS(CHANNEL_BITS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl_in     (ctrl[i]),
      .sum_in      (sum[i]),
      .hue_rem_in  (hue_rem[i]),
      .hue_acc_in  (hue_acc[i]),
      .hue_div_in  (hue_div[i]),
      .sat_rem_in  (sat_rem[i]),
      .sat_acc_in  (sat_acc[i]),
      .sat_div_in  (sat_div[i]),
      .ctrl_out    (ctrl[i+1]),
      .sum_out     (sum[i+1]),
      .hue_rem_out (hue_rem[i+1]),
      .hue_acc_out (hue_acc[i+1]),
      .hue_div_out (hue_div[i+1]),
      .sat_rem_out (sat_rem[i+1]),
      .sat_acc_out (sat_acc[i+1]),
      .sat_div_out (sat_div[i+1])
    );
  end

  // Assemble hue from sextant and fraction; clamp saturation; zero grey
  always_comb begin
    last  = ctrl[QUO_BITS];
    hue_q = hue_acc[QUO_BITS];
    sat_q = sat_acc[QUO_BITS];
    if (last.grey) begin
      hue_next        = '0;
      saturation_next = '0;
    end else begin
      hue_next = HUE_BITS'(last.sext) * HUE_BITS'(HUE_SEXTANT)
               + hue_q[HUE_BITS-1:0];
      saturation_next = sat_q[QUO_BITS-1] ? {SAT_BITS{1'b1}} : sat_q[SAT_BITS-1:0];
    end
  end

  // Register the result
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= last.valid;
    end
    hue           <= hue_next;
    saturation    <= saturation_next;
    lightness_sum <= sum[QUO_BITS];
    alpha_out     <= last.alpha;
    is_grey       <= last.grey;
  end

  // Every accepted pixel yields a result
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted pixel produced no result");

  // Grey results carry zero hue and saturation
  a_grey_zero: assert property (@(posedge clk) disable iff (rst)
    (done && is_grey) |-> (hue == '0 && saturation == '0))
    else $error("grey pixel with nonzero hue or saturation");

  // Colored results stay on the wheel and have nonzero saturation
  a_color_range: assert property (@(posedge clk) disable iff (rst)
    (done && !is_grey) |-> (hue < HUE_BITS'(6 * HUE_SEXTANT) && saturation != '0))
    else $error("colored pixel result out of range");

  // No result appears without a pixel accepted at the matching time
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> $past(start, LATENCY))
    else $error("result without accepted pixel");

endmodule
